// ----- src/stsb_pkg.sv -----
// ----------------------------------------------------------------------------
// stsb_pkg: shared definitions for the sorted table binary search block
// Widths of the item fields, queue sizing, operation codes and the types that
// travel between the front end, the queue and the search engine.
// ----------------------------------------------------------------------------
package stsb_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
  localparam int unsigned INDEX_W             = 8;
  localparam int unsigned VALUE_W             = 32;
  localparam int unsigned COUNT_W             = 9;
  localparam int unsigned QUEUE_DEPTH         = 2;

  // Encoding of the cmd field of an input beat.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic {
    OP_WRITE,
    OP_SEARCH
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  // Push side of the queue, driven by the front end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // Head of the queue, seen by the search engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_CHECK,
    ST_DONE
  } state_e;

endpackage

// ----- src/stsb_if.sv -----
// ----------------------------------------------------------------------------
// stsb_req_if / stsb_rsp_if: valid/ready channels of the search block
// The request channel carries command beats, the response channel carries
// search results.
// ----------------------------------------------------------------------------
interface stsb_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [stsb_pkg::INDEX_W-1:0]       index;
  logic signed [stsb_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface stsb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stsb_pkg::INDEX_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

// ----- src/stsb_front.sv -----
// ----------------------------------------------------------------------------
// stsb_front: request decode
// Turns each accepted request beat into an operation for the queue. Writes to
// positions outside the table are accepted and dropped here.
// ----------------------------------------------------------------------------
module stsb_front #(
  parameter int unsigned TABLE_DEPTH = stsb_pkg::DEFAULT_TABLE_DEPTH
) (
  stsb_req_if.sink        req,
  input  logic            q_full_i,
  output stsb_pkg::push_t push_o
);

  stsb_pkg::op_e op;
  logic          in_range;

  always_comb begin
    case (req.cmd)
      stsb_pkg::CMD_WRITE:  op = stsb_pkg::OP_WRITE;
      stsb_pkg::CMD_SEARCH: op = stsb_pkg::OP_SEARCH;
      default:              op = stsb_pkg::OP_SEARCH;
    endcase
  end

  assign in_range = 32'(req.index) < 32'(TABLE_DEPTH);

  assign req.ready = !q_full_i;

  always_comb begin
    push_o.valid      = req.valid && !q_full_i && ((op == stsb_pkg::OP_SEARCH) || in_range);
    push_o.item.op    = op;
    push_o.item.index = req.index;
    push_o.item.value = req.value;
  end

endmodule

// ----- src/stsb_queue.sv -----
// ----------------------------------------------------------------------------
// stsb_queue: short operation queue
// Decouples request decode from the search engine so that either side can
// stall on its own.
// ----------------------------------------------------------------------------
module stsb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stsb_pkg::push_t push_i,
  output logic            full_o,
  input  logic            pop_i,
  output stsb_pkg::head_t head_o
);

  localparam int unsigned PW = (stsb_pkg::QUEUE_DEPTH > 1) ? $clog2(stsb_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(stsb_pkg::QUEUE_DEPTH + 1);

  stsb_pkg::item_t entry_q [stsb_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CW'(stsb_pkg::QUEUE_DEPTH);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(stsb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(stsb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

// ----- src/stsb_back.sv -----
// ----------------------------------------------------------------------------
// stsb_back: table memory and search engine
// Executes queued writes into the table memory and runs searches with one
// memory read and one compare per probe, then drives the response register.
// ----------------------------------------------------------------------------
module stsb_back #(
  parameter int unsigned TABLE_DEPTH = stsb_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stsb_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  stsb_pkg::head_t                head_i,
  output logic                           pop_o,
  stsb_rsp_if.source                     rsp
);

  localparam int unsigned CNT_W = stsb_pkg::COUNT_W;
  localparam int unsigned IDX_W = stsb_pkg::INDEX_W;
  localparam int unsigned VAL_W = stsb_pkg::VALUE_W;
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned MW    = (AW > CNT_W) ? AW : CNT_W;
  localparam int unsigned IW    = (AW > IDX_W) ? AW : IDX_W;

  logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rd_data_q;

  stsb_pkg::state_e        state_q, state_d;
  logic [CNT_W-1:0]        cfg_q;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        lo_q, lo_d;
  logic [CNT_W-1:0]        hip1_q, hip1_d;
  logic [CNT_W-1:0]        mid_q, mid_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic                    res_found_q, res_found_d;
  logic [IDX_W-1:0]        res_pos_q, res_pos_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q, out_found_d;
  logic [IDX_W-1:0]        out_pos_q, out_pos_d;

  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        lo_m1;
  logic                    probing;
  logic                    out_free;
  logic                    rd_en;
  logic [CNT_W-1:0]        rd_sel;
  logic [MW-1:0]           rd_wide;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [IW-1:0]           wr_wide;
  logic [AW-1:0]           wr_addr;

  // Entries in use, limited to the table depth.
  assign count = (32'(cfg_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cfg_q;

  // The search window is [lo, hip1); mid rounds down like the integer midpoint.
  assign probing = lo_q < hip1_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hip1_q} - 1'b1;
  assign mid     = mid_sum[CNT_W:1];
  assign lo_m1   = lo_q - 1'b1;

  assign out_free = !out_valid_q || rsp.ready;

  assign rd_wide = MW'(rd_sel);
  assign rd_addr = rd_wide[AW-1:0];
  assign wr_wide = IW'(head_i.item.index);
  assign wr_addr = wr_wide[AW-1:0];

  assign rsp.valid    = out_valid_q;
  assign rsp.found    = out_found_q;
  assign rsp.position = out_pos_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stsb_pkg::ST_IDLE: begin
        if (head_i.valid && (head_i.item.op == stsb_pkg::OP_SEARCH)) begin
          state_d = stsb_pkg::ST_SEARCH;
        end
      end
      stsb_pkg::ST_SEARCH: begin
        if (probing) begin
          state_d = stsb_pkg::ST_COMPARE;
        end else if (lo_q == '0) begin
          state_d = stsb_pkg::ST_DONE;
        end else begin
          state_d = stsb_pkg::ST_CHECK;
        end
      end
      stsb_pkg::ST_COMPARE: state_d = stsb_pkg::ST_SEARCH;
      stsb_pkg::ST_CHECK:   state_d = stsb_pkg::ST_DONE;
      stsb_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = stsb_pkg::ST_IDLE;
        end
      end
      default: state_d = stsb_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_sel      = mid;
    lo_d        = lo_q;
    hip1_d      = hip1_q;
    mid_d       = mid_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_valid_d = out_valid_q && !rsp.ready;
    case (state_q)
      stsb_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.op == stsb_pkg::OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            key_d  = head_i.item.value;
            lo_d   = '0;
            hip1_d = count;
          end
        end
      end
      stsb_pkg::ST_SEARCH: begin
        if (probing) begin
          rd_en  = 1'b1;
          rd_sel = mid;
          mid_d  = mid;
        end else if (lo_q == '0) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
        end else begin
          rd_en  = 1'b1;
          rd_sel = lo_m1;
        end
      end
      stsb_pkg::ST_COMPARE: begin
        if (key_q < rd_data_q) begin
          hip1_d = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
      end
      stsb_pkg::ST_CHECK: begin
        res_found_d = rd_data_q == key_q;
        res_pos_d   = (rd_data_q == key_q) ? lo_m1[IDX_W-1:0] : '0;
      end
      stsb_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = res_pos_q;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stsb_pkg::ST_IDLE;
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hip1_q      <= hip1_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[wr_addr] <= head_i.item.value;
    end
    if (rd_en) begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

endmodule

// ----- src/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search: binary search over a sorted table of values
// Stores signed 32-bit entries and answers key lookups with the position of
// the last entry that equals the key.
// ----------------------------------------------------------------------------
// The block keeps a table of TABLE_DEPTH signed 32-bit entries that software
// holds in ascending order. A request beat with cmd 0 writes value into the
// table at index and returns nothing; writes whose index is not below
// TABLE_DEPTH are dropped. A request beat with cmd 1 searches the first
// entries_in_use entries (limited to TABLE_DEPTH) for value and returns one
// response beat: found is 1 and position is the last matching index when the
// key is present, otherwise both are 0. An unsorted table still gets an
// answer from the same probe sequence, and found is only set on an exact
// match. Entries are undefined after reset, so a search must not reach an
// entry that was never written. Requests land in a two-beat queue, so while
// the engine is busy two more beats are taken before the request side
// stalls. The engine handles one operation at a time. A search makes at
// most P = ceil(log2(entries_in_use + 1)) probes: each probe makes one read
// on the single table memory read port and then one compare, and the
// closing equality check needs one more read. A key below every entry in
// use, an empty table included, skips that check. The response sits in an
// output register, so the engine moves on while the response beat waits to
// be taken, unless an earlier response still occupies that register, in
// which case the finished search waits for it. entries_in_use is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while the
// block is idle, which the block itself does not enforce. It takes effect
// for the next search.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = stsb_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [stsb_pkg::COUNT_W-1:0] cfg_wdata_i,
  stsb_req_if.sink                     req_i,
  stsb_rsp_if.source                   rsp_o
);

  // Decoded operation on its way into the queue.
  stsb_pkg::push_t push;
  // Oldest queued operation, offered to the engine.
  stsb_pkg::head_t head;
  logic            q_full;
  logic            pop;

  // Front end: decodes request beats and filters out-of-range writes.
  stsb_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .req      (req_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  // Queue between decode and execution.
  stsb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // Back end: table memory, search engine and response register.
  stsb_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .rsp         (rsp_o)
  );

endmodule
